>>> rtl/oriented_bounding_box_macros.svh
// ----------------------------------------------------------------------------
// Oriented bounding box assertion macros
// Shared concurrent assertion forms, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ORIENTED_BOUNDING_BOX_MACROS_SVH
`define ORIENTED_BOUNDING_BOX_MACROS_SVH

`ifndef SYNTH

`define OBB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define OBB_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`define OBB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define OBB_ASSERT(lbl, clk, rstn, prop, msg)

`define OBB_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)

`define OBB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> rtl/obb_pkg.sv
// ----------------------------------------------------------------------------
// Oriented bounding box package
// Widths, register codes, state and status types shared by the block.
// ----------------------------------------------------------------------------
package obb_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned TERM_W         = 16;
  localparam int unsigned OUT_W          = 19;
  localparam int unsigned ROT_EXTRA      = TERM_W + 2;
  localparam int unsigned BACK_SHIFT     = 24;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned CFG_IDX_W      = 1;

  localparam logic signed [TERM_W-1:0] COS_RESET = 16'sd16384;
  localparam logic signed [TERM_W-1:0] SIN_RESET = 16'sd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS_TERM = 1'b0,
    CFG_SIN_TERM = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CORNER_A = 2'd0,
    CORNER_B = 2'd1,
    CORNER_C = 2'd2,
    CORNER_D = 2'd3
  } corner_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_MUL  = 2'd1,
    BK_ADD  = 2'd2,
    BK_OUT  = 2'd3
  } bk_state_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> rtl/obb_intf.sv
// ----------------------------------------------------------------------------
// Oriented bounding box channels
// Point input channel and box result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface obb_point_if #(
  parameter int unsigned COORD_BITS = obb_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic                  last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

interface obb_box_if;
  logic                               valid;
  logic                               ready;
  logic signed [obb_pkg::OUT_W-1:0]   corner_a_x;
  logic signed [obb_pkg::OUT_W-1:0]   corner_a_y;
  logic signed [obb_pkg::OUT_W-1:0]   corner_b_x;
  logic signed [obb_pkg::OUT_W-1:0]   corner_b_y;
  logic signed [obb_pkg::OUT_W-1:0]   corner_c_x;
  logic signed [obb_pkg::OUT_W-1:0]   corner_c_y;
  logic signed [obb_pkg::OUT_W-1:0]   corner_d_x;
  logic signed [obb_pkg::OUT_W-1:0]   corner_d_y;

  modport source (output valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
                  corner_c_x, corner_c_y, corner_d_x, corner_d_y, input ready);
  modport sink (input valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
                corner_c_x, corner_c_y, corner_d_x, corner_d_y, output ready);
endinterface

>>> rtl/oriented_bounding_box.sv
// ----------------------------------------------------------------------------
// Oriented bounding box
// Fixed-angle oriented bounding box of a stream of edge point sets.
// ----------------------------------------------------------------------------
//  Channel  Dir  Beat
//  pt_i     in   point_x, point_y, last_point
//  box_o    out  corner_a..d x/y, Q15.4
//  cfg      in   cos_term (index 0), sin_term (index 1)
//
// The front end takes one point beat per cycle through a multiply stage
// and an extremes stage. A last point waits in the multiply stage only while
// the two-entry set queue is full. The back end takes one set from the queue
// and steps through a multiply state and an add state per corner on its
// four multipliers before the box beat is shown; it holds that beat until
// taken. Reset clears control state only; there is no clearing pass.
// ----------------------------------------------------------------------------
module oriented_bounding_box #(
  parameter int unsigned COORD_BITS = obb_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  obb_point_if.sink                         pt_i,
  obb_box_if.source                         box_o,
  input  logic                              cfg_we_i,
  input  logic [obb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [obb_pkg::TERM_W-1:0]        cfg_data_i
);

  localparam int unsigned EXT_W = 4 * (COORD_BITS + obb_pkg::ROT_EXTRA);

  logic signed [obb_pkg::TERM_W-1:0] cos_q, sin_q;
  logic                              push, pop;
  logic [EXT_W-1:0]                  ext_push, ext_head;
  obb_pkg::q_stat_t                  q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= obb_pkg::COS_RESET;
      sin_q <= obb_pkg::SIN_RESET;
    end else if (cfg_we_i) begin
      unique case (obb_pkg::cfg_reg_e'(cfg_idx_i))
        obb_pkg::CFG_COS_TERM: cos_q <= $signed(cfg_data_i);
        obb_pkg::CFG_SIN_TERM: sin_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  obb_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pt         (pt_i),
    .cos_term_i (cos_q),
    .sin_term_i (sin_q),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .ext_o      (ext_push)
  );

  obb_queue #(
    .WIDTH (EXT_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (ext_push),
    .pop_i  (pop),
    .data_o (ext_head),
    .stat_o (q_stat)
  );

  obb_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cos_term_i (cos_q),
    .sin_term_i (sin_q),
    .q_stat_i   (q_stat),
    .ext_i      (ext_head),
    .pop_o      (pop),
    .box        (box_o)
  );

endmodule

>>> rtl/obb_front.sv
// ----------------------------------------------------------------------------
// Oriented bounding box front end
// Accepts points, rotates them and tracks the rotated extremes of each set.
// ----------------------------------------------------------------------------
`include "oriented_bounding_box_macros.svh"

module obb_front #(
  parameter int unsigned COORD_BITS = obb_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  obb_point_if.sink                              pt,
  input  logic signed [obb_pkg::TERM_W-1:0]      cos_term_i,
  input  logic signed [obb_pkg::TERM_W-1:0]      sin_term_i,
  input  obb_pkg::q_stat_t                       q_stat_i,
  output logic                                   push_o,
  output logic [4*(COORD_BITS+obb_pkg::ROT_EXTRA)-1:0] ext_o
);

  localparam int unsigned ROT_W  = COORD_BITS + obb_pkg::ROT_EXTRA;
  localparam int unsigned PROD_W = COORD_BITS + 1 + obb_pkg::TERM_W;

  logic signed [COORD_BITS:0] x_s, y_s;
  logic signed [PROD_W-1:0]   xc_d, ys_d, yc_d, xs_d;
  logic signed [PROD_W-1:0]   xc_q, ys_q, yc_q, xs_q;
  logic                       s1_valid_q, s1_last_q;
  logic                       s1_adv, accept;
  logic signed [ROT_W-1:0]    rx, ry;
  logic signed [ROT_W-1:0]    xmin_d, xmax_d, ymin_d, ymax_d;
  logic signed [ROT_W-1:0]    xmin_q, xmax_q, ymin_q, ymax_q;
  logic                       first_q;

  assign x_s = $signed({1'b0, pt.point_x});
  assign y_s = $signed({1'b0, pt.point_y});

  assign xc_d = PROD_W'(x_s) * PROD_W'(cos_term_i);
  assign ys_d = PROD_W'(y_s) * PROD_W'(sin_term_i);
  assign yc_d = PROD_W'(y_s) * PROD_W'(cos_term_i);
  assign xs_d = PROD_W'(x_s) * PROD_W'(sin_term_i);

  assign s1_adv   = s1_valid_q && (!s1_last_q || !q_stat_i.full);
  assign pt.ready = !s1_valid_q || s1_adv;
  assign accept   = pt.valid && pt.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pt.ready) begin
      s1_valid_q <= pt.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_last_q <= pt.last_point;
      xc_q      <= xc_d;
      ys_q      <= ys_d;
      yc_q      <= yc_d;
      xs_q      <= xs_d;
    end
  end

  assign rx = ROT_W'(xc_q) - ROT_W'(ys_q);
  assign ry = ROT_W'(yc_q) + ROT_W'(xs_q);

  always_comb begin
    if (first_q) begin
      xmin_d = rx;
      xmax_d = rx;
      ymin_d = ry;
      ymax_d = ry;
    end else begin
      xmin_d = (rx < xmin_q) ? rx : xmin_q;
      xmax_d = (rx > xmax_q) ? rx : xmax_q;
      ymin_d = (ry < ymin_q) ? ry : ymin_q;
      ymax_d = (ry > ymax_q) ? ry : ymax_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (s1_adv) begin
      first_q <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      xmin_q <= xmin_d;
      xmax_q <= xmax_d;
      ymin_q <= ymin_d;
      ymax_q <= ymax_d;
    end
  end

  assign push_o = s1_valid_q && s1_last_q && !q_stat_i.full;
  assign ext_o  = {xmin_d, xmax_d, ymin_d, ymax_d};

  `OBB_ASSERT_IMPL(a_front_stall_cause, clk_i, rst_ni, s1_valid_q && !pt.ready,
                   s1_last_q && q_stat_i.full, "front stalled without a full queue")
  `OBB_ASSERT_IMPL(a_front_push_last, clk_i, rst_ni, push_o, s1_adv && s1_last_q,
                   "extremes pushed without a last point leaving stage one")

endmodule

>>> rtl/obb_queue.sv
// ----------------------------------------------------------------------------
// Oriented bounding box set queue
// Short queue of finished set extremes between front end and back end.
// ----------------------------------------------------------------------------
`include "oriented_bounding_box_macros.svh"

module obb_queue #(
  parameter int unsigned WIDTH = 4 * (obb_pkg::COORD_BITS_DEF + obb_pkg::ROT_EXTRA)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output obb_pkg::q_stat_t stat_o
);

  localparam int unsigned DEPTH = obb_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign data_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `OBB_ASSERT_IMPL(a_q_no_overflow, clk_i, rst_ni, push_i, !stat_o.full,
                   "push into a full queue")
  `OBB_ASSERT_IMPL(a_q_no_underflow, clk_i, rst_ni, pop_i, !stat_o.empty,
                   "pop from an empty queue")
  `OBB_ASSERT(a_q_count_range, clk_i, rst_ni, cnt_q <= CNT_W'(DEPTH),
              "queue count out of range")

endmodule

>>> rtl/obb_back.sv
// ----------------------------------------------------------------------------
// Oriented bounding box back end
// Rotates the four extreme corners back, one corner at a time through a multiply and an add state.
// ----------------------------------------------------------------------------
`include "oriented_bounding_box_macros.svh"

module obb_back #(
  parameter int unsigned COORD_BITS = obb_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic signed [obb_pkg::TERM_W-1:0]      cos_term_i,
  input  logic signed [obb_pkg::TERM_W-1:0]      sin_term_i,
  input  obb_pkg::q_stat_t                       q_stat_i,
  input  logic [4*(COORD_BITS+obb_pkg::ROT_EXTRA)-1:0] ext_i,
  output logic                                   pop_o,
  obb_box_if.source                              box
);

  localparam int unsigned ROT_W = COORD_BITS + obb_pkg::ROT_EXTRA;
  localparam int unsigned MUL_W = ROT_W + obb_pkg::TERM_W;
  localparam int unsigned SUM_W = MUL_W + 1;
  localparam int unsigned SH_W  = SUM_W - obb_pkg::BACK_SHIFT;
  localparam int unsigned OUT_W = obb_pkg::OUT_W;

  obb_pkg::bk_state_e       state_q, state_d;
  obb_pkg::corner_e         corner_q;
  logic signed [ROT_W-1:0]  xmin_q, xmax_q, ymin_q, ymax_q;
  logic signed [ROT_W-1:0]  px, py;
  logic signed [MUL_W-1:0]  pxc_q, pys_q, pyc_q, pxs_q;
  logic signed [SUM_W-1:0]  bx, by;
  logic signed [OUT_W-1:0]  res_x_q [4];
  logic signed [OUT_W-1:0]  res_y_q [4];

  function automatic logic signed [OUT_W-1:0] sat_field(input logic signed [SUM_W-1:0] v);
    logic [SH_W-1:0]      s;
    logic [SH_W-OUT_W:0]  hi;
    s  = v[SUM_W-1:obb_pkg::BACK_SHIFT];
    hi = s[SH_W-1:OUT_W-1];
    if (hi == '0 || hi == '1) begin
      return s[OUT_W-1:0];
    end else if (s[SH_W-1]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

  always_comb begin
    case (corner_q)
      obb_pkg::CORNER_C, obb_pkg::CORNER_D: px = xmax_q;
      default:                              px = xmin_q;
    endcase
    case (corner_q)
      obb_pkg::CORNER_B, obb_pkg::CORNER_C: py = ymax_q;
      default:                              py = ymin_q;
    endcase
  end

  assign bx = SUM_W'(pxc_q) + SUM_W'(pys_q);
  assign by = SUM_W'(pyc_q) - SUM_W'(pxs_q);

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    box.valid = 1'b0;
    unique case (state_q)
      obb_pkg::BK_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          state_d = obb_pkg::BK_MUL;
        end
      end
      obb_pkg::BK_MUL: begin
        state_d = obb_pkg::BK_ADD;
      end
      obb_pkg::BK_ADD: begin
        state_d = (corner_q == obb_pkg::CORNER_D) ? obb_pkg::BK_OUT : obb_pkg::BK_MUL;
      end
      obb_pkg::BK_OUT: begin
        box.valid = 1'b1;
        if (box.ready) begin
          state_d = obb_pkg::BK_IDLE;
        end
      end
      default: state_d = obb_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= obb_pkg::BK_IDLE;
      corner_q <= obb_pkg::CORNER_A;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        corner_q <= obb_pkg::CORNER_A;
      end else if (state_q == obb_pkg::BK_ADD && corner_q != obb_pkg::CORNER_D) begin
        corner_q <= obb_pkg::corner_e'(corner_q + 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      {xmin_q, xmax_q, ymin_q, ymax_q} <= ext_i;
    end
    if (state_q == obb_pkg::BK_MUL) begin
      pxc_q <= MUL_W'(px) * MUL_W'(cos_term_i);
      pys_q <= MUL_W'(py) * MUL_W'(sin_term_i);
      pyc_q <= MUL_W'(py) * MUL_W'(cos_term_i);
      pxs_q <= MUL_W'(px) * MUL_W'(sin_term_i);
    end
    if (state_q == obb_pkg::BK_ADD) begin
      res_x_q[corner_q] <= sat_field(bx);
      res_y_q[corner_q] <= sat_field(by);
    end
  end

  assign box.corner_a_x = res_x_q[obb_pkg::CORNER_A];
  assign box.corner_a_y = res_y_q[obb_pkg::CORNER_A];
  assign box.corner_b_x = res_x_q[obb_pkg::CORNER_B];
  assign box.corner_b_y = res_y_q[obb_pkg::CORNER_B];
  assign box.corner_c_x = res_x_q[obb_pkg::CORNER_C];
  assign box.corner_c_y = res_y_q[obb_pkg::CORNER_C];
  assign box.corner_d_x = res_x_q[obb_pkg::CORNER_D];
  assign box.corner_d_y = res_y_q[obb_pkg::CORNER_D];

  `OBB_ASSERT_NEXT(a_back_done_after_d, clk_i, rst_ni,
                   state_q == obb_pkg::BK_ADD && corner_q == obb_pkg::CORNER_D,
                   state_q == obb_pkg::BK_OUT, "box not presented after the last corner")
  `OBB_ASSERT_IMPL(a_back_out_full_set, clk_i, rst_ni, box.valid,
                   corner_q == obb_pkg::CORNER_D, "box presented before all corners")

endmodule

>>> verif/obb_box_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Oriented bounding box checker
// Watches the point and box channels and the register port, predicts each
// box beat from the accepted point beats and compares it field by field.
// ----------------------------------------------------------------------------
module obb_box_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  obb_point_if                          pt_i,
  obb_box_if                            box_i,
  input  logic                          cfg_we_i,
  input  logic [obb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [obb_pkg::TERM_W-1:0]    cfg_data_i,
  output int unsigned                   error_count_o,
  output int unsigned                   boxes_pending_o,
  output int unsigned                   points_seen_o,
  output int unsigned                   boxes_seen_o
);

  localparam int unsigned REPORT_LIMIT = 10;
  localparam longint      OUT_HI       = (longint'(1) << (obb_pkg::OUT_W - 1)) - 1;
  localparam longint      OUT_LO       = -(longint'(1) << (obb_pkg::OUT_W - 1));

  // Index 2k holds x and 2k+1 holds y of corner k, corner a first.
  typedef logic [7:0][obb_pkg::OUT_W-1:0] box_beat_t;

  box_beat_t   expected_boxes[$];
  longint      cos_q;
  longint      sin_q;
  longint      rx_lo;
  longint      rx_hi;
  longint      ry_lo;
  longint      ry_hi;
  bit          set_open;
  int unsigned errors;
  int unsigned points;
  int unsigned boxes;

  function automatic logic [obb_pkg::OUT_W-1:0] to_q15_4(longint acc);
    longint q;
    q = acc >>> obb_pkg::BACK_SHIFT;
    if (q > OUT_HI) q = OUT_HI;
    if (q < OUT_LO) q = OUT_LO;
    return q[obb_pkg::OUT_W-1:0];
  endfunction

  function automatic box_beat_t box_from_extremes(longint ct, longint st, longint xl,
                                                  longint xh, longint yl, longint yh);
    longint    px[4];
    longint    py[4];
    box_beat_t beat;
    px = '{xl, xl, xh, xh};
    py = '{yl, yh, yh, yl};
    for (int k = 0; k < 4; k++) begin
      beat[2*k]   = to_q15_4(px[k] * ct + py[k] * st);
      beat[2*k+1] = to_q15_4(py[k] * ct - px[k] * st);
    end
    return beat;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    longint    x;
    longint    y;
    longint    rx;
    longint    ry;
    box_beat_t want;
    box_beat_t got;
    if (!rst_ni) begin
      cos_q = obb_pkg::COS_RESET;
      sin_q = obb_pkg::SIN_RESET;
      set_open = 1'b0;
      expected_boxes.delete();
      errors = 0;
      points = 0;
      boxes = 0;
    end else begin
      if (pt_i.valid && pt_i.ready) begin
        x = pt_i.point_x;
        y = pt_i.point_y;
        rx = x * cos_q - y * sin_q;
        ry = y * cos_q + x * sin_q;
        if (!set_open) begin
          rx_lo = rx;
          rx_hi = rx;
          ry_lo = ry;
          ry_hi = ry;
        end else begin
          if (rx < rx_lo) rx_lo = rx;
          if (rx > rx_hi) rx_hi = rx;
          if (ry < ry_lo) ry_lo = ry;
          if (ry > ry_hi) ry_hi = ry;
        end
        if (pt_i.last_point) begin
          expected_boxes.insert(expected_boxes.size(),
                                box_from_extremes(cos_q, sin_q, rx_lo, rx_hi,
                                                  ry_lo, ry_hi));
          set_open = 1'b0;
        end else begin
          set_open = 1'b1;
        end
        points++;
      end
      if (box_i.valid && box_i.ready) begin
        boxes++;
        got = {box_i.corner_d_y, box_i.corner_d_x, box_i.corner_c_y, box_i.corner_c_x,
               box_i.corner_b_y, box_i.corner_b_x, box_i.corner_a_y, box_i.corner_a_x};
        if (expected_boxes.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("ERROR: box beat %0d arrived with no point set pending", boxes);
        end else begin
          want = expected_boxes.pop_front();
          for (int k = 0; k < 8; k++) begin
            if (got[k] !== want[k]) begin
              errors++;
              if (errors <= REPORT_LIMIT)
                $display("ERROR: box beat %0d corner_%c_%s expected %0d got %0d", boxes,
                         8'h61 + k / 2, (k % 2) ? "y" : "x", $signed(want[k]),
                         $signed(got[k]));
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (obb_pkg::cfg_reg_e'(cfg_idx_i))
          obb_pkg::CFG_COS_TERM: cos_q = signed'(cfg_data_i);
          obb_pkg::CFG_SIN_TERM: sin_q = signed'(cfg_data_i);
          default: ;
        endcase
      end
    end
    error_count_o   <= errors;
    boxes_pending_o <= expected_boxes.size();
    points_seen_o   <= points;
    boxes_seen_o    <= boxes;
  end

endmodule

>>> verif/tb_oriented_bounding_box.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Oriented bounding box testbench
// Drives edge point sets under several rotation settings, with bursty input,
// a stalling output and one long output hold-off; the checker predicts and
// compares every box beat.
// ----------------------------------------------------------------------------
module tb_oriented_bounding_box;

  localparam int unsigned COORD_W       = obb_pkg::COORD_BITS_DEF;
  localparam int unsigned TERM_W        = obb_pkg::TERM_W;
  localparam int unsigned RESET_CYCLES  = 9;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned HOLD_POINTS   = 40;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_POINTS  = 90;

  typedef enum int {RX_STEADY, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_e;
  typedef enum int {ANGLE_UNIT, ANGLE_ANY, ANGLE_EDGE} angle_kind_e;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [obb_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [TERM_W-1:0]             cfg_data;

  int unsigned error_count;
  int unsigned boxes_pending;
  int unsigned points_seen;
  int unsigned boxes_seen;
  int unsigned burst_left  = 0;
  int unsigned stall_count = 0;
  int unsigned angle_count = 0;
  int unsigned hold_left   = 0;
  int unsigned mode_left   = 0;
  bit          steady      = 1'b0;
  bit          hold_req    = 1'b0;
  bit          hold_taken  = 1'b0;
  rx_mode_e    rx_mode     = RX_STEADY;

  obb_point_if #(.COORD_BITS(COORD_W)) pt_if ();
  obb_box_if                           box_if ();

  oriented_bounding_box #(
    .COORD_BITS(COORD_W)
  ) u_top (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .pt_i      (pt_if),
    .box_o     (box_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  obb_box_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .pt_i           (pt_if),
    .box_i          (box_if),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .error_count_o  (error_count),
    .boxes_pending_o(boxes_pending),
    .points_seen_o  (points_seen),
    .boxes_seen_o   (boxes_seen)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      box_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      box_if.ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= LONG_HOLD;
      box_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
        mode_left <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_STEADY: box_if.ready <= 1'b1;
        RX_MOSTLY: box_if.ready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE: box_if.ready <= ($urandom_range(0, 3) == 0);
        default:   box_if.ready <= !box_if.ready;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (pt_if.valid && pt_if.ready) || (box_if.valid && box_if.ready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("Watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic last);
    int unsigned gap;
    if (!steady && burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        pt_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    pt_if.valid      <= 1'b1;
    pt_if.point_x    <= x;
    pt_if.point_y    <= y;
    pt_if.last_point <= last;
    do @(posedge clk); while (!pt_if.ready);
  endtask

  task automatic drain();
    pt_if.valid <= 1'b0;
    @(posedge clk);
    while (boxes_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_angle(input bit do_cos, input bit do_sin,
                            input logic [TERM_W-1:0] c, input logic [TERM_W-1:0] s);
    if (do_cos) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= obb_pkg::CFG_COS_TERM;
      cfg_data <= c;
      @(posedge clk);
    end
    if (do_sin) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= obb_pkg::CFG_SIN_TERM;
      cfg_data <= s;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    angle_count++;
  endtask

  function automatic logic [TERM_W-1:0] pick_term(angle_kind_e kind);
    case (kind)
      ANGLE_UNIT: return TERM_W'($urandom_range(0, 32768) - 16384);
      ANGLE_ANY:  return TERM_W'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0:       return 16'h8000;
          1:       return 16'h7fff;
          2:       return 16'h4000;
          3:       return 16'hc000;
          default: return 16'h0000;
        endcase
      end
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(logic [COORD_W-1:0] center);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return COORD_W'($urandom);
      default: return center + COORD_W'($urandom_range(0, 63)) - COORD_W'(32);
    endcase
  endfunction

  task automatic send_random_set(input int unsigned len);
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    cx = COORD_W'($urandom);
    cy = COORD_W'($urandom);
    for (int unsigned i = 0; i < len; i++)
      send_point(pick_coord(cx), pick_coord(cy), i == len - 1);
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    angle_kind_e kind;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = obb_pkg::CFG_COS_TERM;
    cfg_data         = '0;
    pt_if.valid      = 1'b0;
    pt_if.point_x    = '0;
    pt_if.point_y    = '0;
    pt_if.last_point = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_point(12'd0, 12'd0, 1'b1);
    send_point(12'hfff, 12'hfff, 1'b1);
    send_point(12'hfff, 12'd0, 1'b0);
    send_point(12'd0, 12'hfff, 1'b0);
    send_point(12'd2048, 12'd1000, 1'b1);
    send_point(12'd1, 12'd2, 1'b0);
    send_point(12'd4094, 12'd4093, 1'b0);
    send_point(12'h555, 12'haaa, 1'b0);
    send_point(12'haaa, 12'h555, 1'b1);
    drain();
    load_angle(1'b1, 1'b1, 16'h7fff, 16'h7fff);
    send_point(12'hfff, 12'd0, 1'b0);
    send_point(12'd0, 12'hfff, 1'b1);
    send_point(12'hfff, 12'hfff, 1'b1);
    drain();
    load_angle(1'b1, 1'b1, 16'h8000, 16'h8000);
    send_point(12'hfff, 12'hfff, 1'b0);
    send_point(12'd0, 12'd0, 1'b1);
    send_point(12'hfff, 12'd0, 1'b1);
    drain();
    load_angle(1'b1, 1'b1, 16'h0000, 16'h4000);
    send_point(12'd100, 12'd4000, 1'b0);
    send_point(12'd4000, 12'd100, 1'b1);
    drain();
    load_angle(1'b1, 1'b1, 16'hc000, 16'h0000);
    send_point(12'd7, 12'hfff, 1'b0);
    send_point(12'hfff, 12'd9, 1'b1);
    drain();

    // Output held off while mostly single-point sets keep arriving back to back.
    load_angle(1'b1, 1'b1, pick_term(ANGLE_UNIT), pick_term(ANGLE_UNIT));
    steady = 1'b1;
    hold_req = 1'b1;
    for (int unsigned i = 0; i < HOLD_POINTS; i++)
      send_point(COORD_W'($urandom), COORD_W'($urandom), ($urandom_range(0, 4) != 0));
    send_point(COORD_W'($urandom), COORD_W'($urandom), 1'b1);
    steady = 1'b0;
    drain();

    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      kind = angle_kind_e'(phase % 3);
      case ($urandom_range(0, 3))
        0:       load_angle(1'b1, 1'b0, pick_term(kind), '0);
        1:       load_angle(1'b0, 1'b1, '0, pick_term(kind));
        default: load_angle(1'b1, 1'b1, pick_term(kind), pick_term(kind));
      endcase
      sent = 0;
      while (sent < PHASE_POINTS) begin
        len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 40);
        send_random_set(len);
        sent += len;
      end
      drain();
    end

    $display("Run covered %0d point beats and %0d box beats over %0d angle settings.",
             points_seen, boxes_seen, angle_count);
    $display("Included single-point sets, saturating corners and a %0d-cycle output hold.",
             LONG_HOLD);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
